// ===== rtl/cfc_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the control frame checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int CRC_OFFSET  = 30;
    localparam int IDX_W       = $clog2(FRAME_BYTES + 2);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_MSB      = 16'h8000;
    localparam logic [7:0]  DPAD_NEUTRAL = 8'd8;
    localparam logic [7:0]  BATT_MAX     = 8'd100;
    localparam logic [7:0]  BATT_UNKNOWN = 8'd255;

    typedef enum logic [2:0] {
        RC_OK      = 3'd0,
        RC_LENGTH  = 3'd1,
        RC_MAGIC   = 3'd2,
        RC_VERSION = 3'd3,
        RC_TYPE    = 3'd4,
        RC_CRC     = 3'd5,
        RC_DPAD    = 3'd6,
        RC_BATTERY = 3'd7
    } t_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC_FIRST  = 2'd0,
        CFG_MAGIC_SECOND = 2'd1,
        CFG_VERSION      = 2'd2,
        CFG_CTRL_TYPE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] magic_first;
        logic [7:0] magic_second;
        logic [7:0] protocol_version;
        logic [7:0] control_type;
    } t_cfg;

    typedef struct packed {
        t_code       code;
        logic [15:0] sequence_res;
        logic [31:0] uptime_ms;
        logic [15:0] control_flags;
        logic [15:0] buttons;
        logic [7:0]  dpad;
        logic [31:0] sticks;
        logic [15:0] triggers;
        logic [7:0]  sender_battery;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cfc_in_if.sv =====
// Byte request channel of the control frame checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfc_out_if.sv =====
// Verdict request channel of the control frame checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cfc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_code;
    logic [15:0] sequence_res;
    logic [31:0] uptime_ms;
    logic [15:0] control_flags;
    logic [15:0] buttons;
    logic [7:0]  dpad;
    logic [31:0] sticks;
    logic [15:0] triggers;
    logic [7:0]  sender_battery;

    modport source (output valid, output result_code, output sequence_res, output uptime_ms,
                    output control_flags, output buttons, output dpad, output sticks,
                    output triggers, output sender_battery, input ready);
    modport sink   (input valid, input result_code, input sequence_res, input uptime_ms,
                    input control_flags, input buttons, input dpad, input sticks,
                    input triggers, input sender_battery, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfc_frame.sv =====
// Per-frame state: byte count, CRC accumulator, header checks and field capture.
// Produces the verdict for a final byte combinationally. Depends on cfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfc_frame
    import cfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    logic [IDX_W-1:0] r_idx,   n_idx,   u_idx;
    logic [15:0]      r_crc,   n_crc,   u_crc;
    t_code            r_fault, n_fault, u_fault;
    logic [15:0]      r_crc_rx, n_crc_rx, u_crc_rx;
    logic [15:0]      r_seq,   n_seq,   u_seq;
    logic [31:0]      r_up,    n_up,    u_up;
    logic [15:0]      r_flags, n_flags, u_flags;
    logic [15:0]      r_btn,   n_btn,   u_btn;
    logic [7:0]       r_dpad,  n_dpad,  u_dpad;
    logic [31:0]      r_stk,   n_stk,   u_stk;
    logic [15:0]      r_trg,   n_trg,   u_trg;
    logic [7:0]       r_bat,   n_bat,   u_bat;
    logic             take;
    logic             fields_ok;
    t_code            code;

    always_comb begin
        u_idx    = r_idx;
        u_crc    = r_crc;
        u_fault  = r_fault;
        u_crc_rx = r_crc_rx;
        u_seq    = r_seq;
        u_up     = r_up;
        u_flags  = r_flags;
        u_btn    = r_btn;
        u_dpad   = r_dpad;
        u_stk    = r_stk;
        u_trg    = r_trg;
        u_bat    = r_bat;

        take = (r_idx < IDX_W'(FRAME_BYTES));
        if (take) begin
            if (r_idx < IDX_W'(CRC_OFFSET)) begin
                u_crc = crc_byte(r_crc, i_data_byte);
            end
            if (r_idx == IDX_W'(CRC_OFFSET)) begin
                u_crc_rx = {i_data_byte, r_crc_rx[7:0]};
            end
            if (r_idx == IDX_W'(CRC_OFFSET + 1)) begin
                u_crc_rx = {r_crc_rx[15:8], i_data_byte};
            end
            case (r_idx) inside
                IDX_W'(0): begin
                    if (i_data_byte != i_cfg.magic_first && r_fault == RC_OK) u_fault = RC_MAGIC;
                end
                IDX_W'(1): begin
                    if (i_data_byte != i_cfg.magic_second && r_fault == RC_OK) u_fault = RC_MAGIC;
                end
                IDX_W'(2): begin
                    if (i_data_byte != i_cfg.protocol_version && r_fault == RC_OK) begin
                        u_fault = RC_VERSION;
                    end
                end
                IDX_W'(3): begin
                    if (i_data_byte != i_cfg.control_type && r_fault == RC_OK) u_fault = RC_TYPE;
                end
                IDX_W'(4), IDX_W'(5): u_seq = {r_seq[7:0], i_data_byte};
                IDX_W'(6), IDX_W'(7), IDX_W'(8), IDX_W'(9): u_up = {r_up[23:0], i_data_byte};
                IDX_W'(10), IDX_W'(11): u_flags = {r_flags[7:0], i_data_byte};
                IDX_W'(12), IDX_W'(13): u_btn = {r_btn[7:0], i_data_byte};
                IDX_W'(14): u_dpad = i_data_byte;
                IDX_W'(15), IDX_W'(16), IDX_W'(17), IDX_W'(18): u_stk = {r_stk[23:0], i_data_byte};
                IDX_W'(19), IDX_W'(20): u_trg = {r_trg[7:0], i_data_byte};
                IDX_W'(21): u_bat = i_data_byte;
                default: ;
            endcase
        end
        // count saturates one past a full frame
        if (r_idx <= IDX_W'(FRAME_BYTES)) begin
            u_idx = r_idx + IDX_W'(1);
        end

        if (u_idx != IDX_W'(FRAME_BYTES)) begin
            code = RC_LENGTH;
        end else if (u_fault != RC_OK) begin
            code = u_fault;
        end else if (u_crc_rx != u_crc) begin
            code = RC_CRC;
        end else if (u_dpad > DPAD_NEUTRAL) begin
            code = RC_DPAD;
        end else if (u_bat > BATT_MAX && u_bat != BATT_UNKNOWN) begin
            code = RC_BATTERY;
        end else begin
            code = RC_OK;
        end

        fields_ok = (code == RC_OK) || (code == RC_DPAD) || (code == RC_BATTERY);
        o_result                = '0;
        o_result.code           = code;
        if (fields_ok) begin
            o_result.sequence_res   = u_seq;
            o_result.uptime_ms      = u_up;
            o_result.control_flags  = u_flags;
            o_result.buttons        = u_btn;
            o_result.dpad           = u_dpad;
            o_result.sticks         = u_stk;
            o_result.triggers       = u_trg;
            o_result.sender_battery = u_bat;
        end

        if (i_last_byte) begin
            n_idx    = '0;
            n_crc    = CRC_INIT;
            n_fault  = RC_OK;
            n_crc_rx = '0;
            n_seq    = '0;
            n_up     = '0;
            n_flags  = '0;
            n_btn    = '0;
            n_dpad   = '0;
            n_stk    = '0;
            n_trg    = '0;
            n_bat    = '0;
        end else begin
            n_idx    = u_idx;
            n_crc    = u_crc;
            n_fault  = u_fault;
            n_crc_rx = u_crc_rx;
            n_seq    = u_seq;
            n_up     = u_up;
            n_flags  = u_flags;
            n_btn    = u_btn;
            n_dpad   = u_dpad;
            n_stk    = u_stk;
            n_trg    = u_trg;
            n_bat    = u_bat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_crc    <= CRC_INIT;
            r_fault  <= RC_OK;
            r_crc_rx <= '0;
            r_seq    <= '0;
            r_up     <= '0;
            r_flags  <= '0;
            r_btn    <= '0;
            r_dpad   <= '0;
            r_stk    <= '0;
            r_trg    <= '0;
            r_bat    <= '0;
        end else if (i_step) begin
            r_idx    <= n_idx;
            r_crc    <= n_crc;
            r_fault  <= n_fault;
            r_crc_rx <= n_crc_rx;
            r_seq    <= n_seq;
            r_up     <= n_up;
            r_flags  <= n_flags;
            r_btn    <= n_btn;
            r_dpad   <= n_dpad;
            r_stk    <= n_stk;
            r_trg    <= n_trg;
            r_bat    <= n_bat;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(FRAME_BYTES + 1))
        else $error("byte count past saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last_byte |=> r_idx == '0 && r_crc == CRC_INIT && r_fault == RC_OK)
        else $error("frame state not cleared after final byte");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_idx) && $stable(r_crc) && $stable(r_fault))
        else $error("frame state moved without a byte");

endmodule

`default_nettype wire

// ===== rtl/control_frame_checker.sv =====
// Control frame checker top level: config registers, input register, result register.
// Depends on cfc_pkg, cfc_in_if, cfc_out_if and cfc_frame.
// Throughput: one byte per cycle; a final byte waits only while the previous verdict is held off.
// Path: an accepted final byte sits in the input register; the frame logic then loads the result
//   register, which drives the verdict.
// Reset: synchronous, active low; clears config registers to zero and frame state to its start.
`timescale 1ns / 1ps
`default_nettype none

module control_frame_checker
    import cfc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    cfc_in_if.sink                     i_in,
    cfc_out_if.source                  o_out
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    frame_result;
    logic       adv;

    // a final byte may only move on when the result register is free
    assign adv        = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAGIC_FIRST:  r_cfg.magic_first      <= i_cfg_data;
                CFG_MAGIC_SECOND: r_cfg.magic_second     <= i_cfg_data;
                CFG_VERSION:      r_cfg.protocol_version <= i_cfg_data;
                CFG_CTRL_TYPE:    r_cfg.control_type     <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    cfc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (adv),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .i_cfg       (r_cfg),
        .o_result    (frame_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= frame_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_code    = r_out.code;
    assign o_out.sequence_res   = r_out.sequence_res;
    assign o_out.uptime_ms      = r_out.uptime_ms;
    assign o_out.control_flags  = r_out.control_flags;
    assign o_out.buttons        = r_out.buttons;
    assign o_out.dpad           = r_out.dpad;
    assign o_out.sticks         = r_out.sticks;
    assign o_out.triggers       = r_out.triggers;
    assign o_out.sender_battery = r_out.sender_battery;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_out_valid)
        else $error("final byte produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(adv && r_in_last))
        else $error("pending result overwritten");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.code != RC_OK && r_out.code != RC_DPAD
            && r_out.code != RC_BATTERY
        |-> r_out.sequence_res == '0 && r_out.uptime_ms == '0 && r_out.dpad == '0
            && r_out.sticks == '0 && r_out.sender_battery == '0)
        else $error("fields not zero on rejected frame");

endmodule

`default_nettype wire

// ===== verif/control_frame_checker_tb.sv =====
// Self-checking testbench for control_frame_checker: drives byte requests, predicts verdicts.
// Depends on cfc_pkg, cfc_in_if, cfc_out_if and the control_frame_checker RTL.
`timescale 1ns / 1ps
`default_nettype none

module control_frame_checker_tb;
    import cfc_pkg::*;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int PICK        = -1;
    localparam int LONG_HOLD   = 400;

    typedef enum int {
        FK_GOOD, FK_MAGIC, FK_VERSION, FK_TYPE, FK_CRC, FK_DPAD, FK_BATTERY,
        FK_MULTI, FK_SHORT, FK_LONG, FK_NOISE
    } t_frame_kind;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
    } t_byte_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cfc_in_if  in_if ();
    cfc_out_if out_if ();

    control_frame_checker i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_byte_req byte_q[$];
    t_byte_req drv_item;
    int        drv_gap = 0;
    t_result   verdict_q[$];
    t_result   exp_v;
    t_cfg      cfg_model = '0;
    int        err_cnt = 0;
    int        verdicts_seen = 0;
    int        rdy_stall = 0;
    int        rdy_hold = 0;
    int        rdy_cycle = 0;
    bit        hold_done = 1'b0;

    // frame state of the predictor
    int          fr_idx;
    logic [15:0] fr_crc;
    logic [15:0] fr_crc_rx;
    t_code       fr_fault;
    logic [15:0] fr_seq;
    logic [31:0] fr_uptime;
    logic [15:0] fr_flags;
    logic [15:0] fr_buttons;
    logic [7:0]  fr_dpad;
    logic [31:0] fr_sticks;
    logic [15:0] fr_triggers;
    logic [7:0]  fr_batt;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bitwise CRC-16/CCITT-FALSE update, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FK_GOOD;
        if (r < 60) return FK_MAGIC;
        if (r < 64) return FK_VERSION;
        if (r < 68) return FK_TYPE;
        if (r < 74) return FK_CRC;
        if (r < 79) return FK_DPAD;
        if (r < 84) return FK_BATTERY;
        if (r < 88) return FK_MULTI;
        if (r < 92) return FK_SHORT;
        if (r < 96) return FK_LONG;
        return FK_NOISE;
    endfunction

    task automatic frame_clear();
        fr_idx      = 0;
        fr_crc      = CRC_INIT;
        fr_crc_rx   = '0;
        fr_fault    = RC_OK;
        fr_seq      = '0;
        fr_uptime   = '0;
        fr_flags    = '0;
        fr_buttons  = '0;
        fr_dpad     = '0;
        fr_sticks   = '0;
        fr_triggers = '0;
        fr_batt     = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        t_result v;
        t_code   code;
        if (fr_idx < FRAME_BYTES) begin
            if (fr_idx < CRC_OFFSET) begin
                fr_crc = crc16_step(fr_crc, b);
            end
            if (fr_idx == CRC_OFFSET) begin
                fr_crc_rx[15:8] = b;
            end
            if (fr_idx == CRC_OFFSET + 1) begin
                fr_crc_rx[7:0] = b;
            end
            case (fr_idx)
                0: if (b != cfg_model.magic_first && fr_fault == RC_OK) fr_fault = RC_MAGIC;
                1: if (b != cfg_model.magic_second && fr_fault == RC_OK) fr_fault = RC_MAGIC;
                2: if (b != cfg_model.protocol_version && fr_fault == RC_OK) fr_fault = RC_VERSION;
                3: if (b != cfg_model.control_type && fr_fault == RC_OK) fr_fault = RC_TYPE;
                4, 5: fr_seq = {fr_seq[7:0], b};
                6, 7, 8, 9: fr_uptime = {fr_uptime[23:0], b};
                10, 11: fr_flags = {fr_flags[7:0], b};
                12, 13: fr_buttons = {fr_buttons[7:0], b};
                14: fr_dpad = b;
                15, 16, 17, 18: fr_sticks = {fr_sticks[23:0], b};
                19, 20: fr_triggers = {fr_triggers[7:0], b};
                21: fr_batt = b;
                default: ;
            endcase
        end
        if (fr_idx <= FRAME_BYTES) begin
            fr_idx++;
        end
        if (last) begin
            if (fr_idx != FRAME_BYTES) code = RC_LENGTH;
            else if (fr_fault != RC_OK) code = fr_fault;
            else if (fr_crc_rx != fr_crc) code = RC_CRC;
            else if (fr_dpad > DPAD_NEUTRAL) code = RC_DPAD;
            else if (fr_batt > BATT_MAX && fr_batt != BATT_UNKNOWN) code = RC_BATTERY;
            else code = RC_OK;
            v = '0;
            v.code = code;
            if (code == RC_OK || code == RC_DPAD || code == RC_BATTERY) begin
                v.sequence_res   = fr_seq;
                v.uptime_ms      = fr_uptime;
                v.control_flags  = fr_flags;
                v.buttons        = fr_buttons;
                v.dpad           = fr_dpad;
                v.sticks         = fr_sticks;
                v.triggers       = fr_triggers;
                v.sender_battery = fr_batt;
            end
            verdict_q.push_back(v);
            frame_clear();
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, actual %0h", fname, exp_val, act_val);
            err_cnt++;
        end
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [7:0] d);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        case (idx)
            CFG_MAGIC_FIRST:  cfg_model.magic_first = d;
            CFG_MAGIC_SECOND: cfg_model.magic_second = d;
            CFG_VERSION:      cfg_model.protocol_version = d;
            CFG_CTRL_TYPE:    cfg_model.control_type = d;
            default: ;
        endcase
    endtask

    task automatic queue_frame(input t_frame_kind kind, input int fill, input int dpad_v,
                               input int batt_v, input int len_v);
        logic [7:0]  fb [0:FRAME_BYTES+7];
        logic [15:0] c;
        int          n;
        int          idx;
        bit          calm;
        t_byte_req   req;
        for (int k = 0; k < FRAME_BYTES + 8; k++) begin
            fb[k] = (fill == FILL_ZERO) ? 8'h00 :
                    (fill == FILL_ONES) ? 8'hFF : 8'($urandom_range(0, 255));
        end
        if (kind != FK_NOISE) begin
            fb[0] = cfg_model.magic_first;
            fb[1] = cfg_model.magic_second;
            fb[2] = cfg_model.protocol_version;
            fb[3] = cfg_model.control_type;
            if (fill == FILL_RANDOM) begin
                fb[14] = 8'($urandom_range(0, DPAD_NEUTRAL));
                fb[21] = ($urandom_range(0, 9) == 0) ? BATT_UNKNOWN
                                                     : 8'($urandom_range(0, BATT_MAX));
            end
            if (dpad_v >= 0) fb[14] = 8'(dpad_v);
            if (batt_v >= 0) fb[21] = 8'(batt_v);
            case (kind)
                FK_MAGIC: begin
                    idx = $urandom_range(0, 1);
                    fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
                end
                FK_VERSION: fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
                FK_TYPE:    fb[3] = fb[3] ^ 8'($urandom_range(1, 255));
                FK_DPAD:    fb[14] = 8'($urandom_range(9, 255));
                FK_BATTERY: fb[21] = 8'($urandom_range(101, 254));
                FK_MULTI: begin
                    // several faults at once: the earliest check must win
                    if ($urandom_range(0, 1) == 1) fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
                    fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
                    fb[3] = fb[3] ^ 8'($urandom_range(1, 255));
                    fb[14] = 8'($urandom_range(9, 255));
                    fb[21] = 8'($urandom_range(101, 254));
                end
                default: ;
            endcase
            c = CRC_INIT;
            for (int k = 0; k < CRC_OFFSET; k++) begin
                c = crc16_step(c, fb[k]);
            end
            fb[CRC_OFFSET]     = c[15:8];
            fb[CRC_OFFSET + 1] = c[7:0];
            if (kind == FK_CRC || kind == FK_MULTI) begin
                idx = CRC_OFFSET + $urandom_range(0, 1);
                fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
            end
        end
        case (kind)
            FK_SHORT: n = $urandom_range(1, FRAME_BYTES - 1);
            FK_LONG:  n = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 8);
            FK_NOISE: n = $urandom_range(1, FRAME_BYTES + 8);
            default:  n = FRAME_BYTES;
        endcase
        if (len_v > 0) n = len_v;
        calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            req.data = fb[k];
            req.last = (k == n - 1);
            req.gap  = calm ? 0 : pick_gap();
            byte_q.push_back(req);
        end
    endtask

    // checked at the falling edge, after the rising-edge updates have settled
    task automatic wait_idle();
        while (byte_q.size() != 0 || in_if.valid || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // byte request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= '0;
            in_if.last_byte <= 1'b0;
            drv_gap         <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (drv_gap != 0) begin
                in_if.valid <= 1'b0;
                drv_gap     <= drv_gap - 1;
            end else if (byte_q.size() != 0) begin
                drv_item = byte_q.pop_front();
                in_if.valid     <= 1'b1;
                in_if.data_byte <= drv_item.data;
                in_if.last_byte <= drv_item.last;
                drv_gap         <= drv_item.gap;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // predictor, fed by accepted byte requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_clear();
        end else if (in_if.valid && in_if.ready) begin
            absorb_byte(in_if.data_byte, in_if.last_byte);
        end
    end

    // verdict receiver: random stalls, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rdy_stall    <= 0;
            rdy_hold     <= 0;
            rdy_cycle    <= 0;
        end else begin
            rdy_cycle <= rdy_cycle + 1;
            if (rdy_hold != 0) begin
                out_if.ready <= 1'b0;
                rdy_hold     <= rdy_hold - 1;
            end else if (!hold_done && verdicts_seen >= 10) begin
                hold_done    <= 1'b1;
                rdy_hold     <= LONG_HOLD;
                out_if.ready <= 1'b0;
            end else if (rdy_stall != 0) begin
                out_if.ready <= 1'b0;
                rdy_stall    <= rdy_stall - 1;
            end else if ((rdy_cycle % 512) >= 128 && $urandom_range(0, 99) < 25) begin
                out_if.ready <= 1'b0;
                rdy_stall    <= pick_gap();
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // verdict monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            verdicts_seen <= verdicts_seen + 1;
            if (verdict_q.size() == 0) begin
                $error("verdict with no request pending: code %0d", out_if.result_code);
                err_cnt++;
            end else begin
                exp_v = verdict_q.pop_front();
                check_field("result_code", 32'(exp_v.code), 32'(out_if.result_code));
                check_field("sequence_res", 32'(exp_v.sequence_res), 32'(out_if.sequence_res));
                check_field("uptime_ms", exp_v.uptime_ms, out_if.uptime_ms);
                check_field("control_flags", 32'(exp_v.control_flags), 32'(out_if.control_flags));
                check_field("buttons", 32'(exp_v.buttons), 32'(out_if.buttons));
                check_field("dpad", 32'(exp_v.dpad), 32'(out_if.dpad));
                check_field("sticks", exp_v.sticks, out_if.sticks);
                check_field("triggers", 32'(exp_v.triggers), 32'(out_if.triggers));
                check_field("sender_battery", 32'(exp_v.sender_battery),
                            32'(out_if.sender_battery));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_cfg setting;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 4; p++) begin
            case (p)
                1:       setting = '0;
                2:       setting = '1;
                default: setting = t_cfg'($urandom());
            endcase
            cfg_write(CFG_MAGIC_FIRST, setting.magic_first);
            cfg_write(CFG_MAGIC_SECOND, setting.magic_second);
            cfg_write(CFG_VERSION, setting.protocol_version);
            cfg_write(CFG_CTRL_TYPE, setting.control_type);
            @(posedge i_clk);
            cfg_we <= 1'b0;

            if (p == 0) begin
                queue_frame(FK_GOOD, FILL_ZERO, PICK, PICK, PICK);
                queue_frame(FK_GOOD, FILL_ONES, PICK, PICK, PICK);
                queue_frame(FK_GOOD, FILL_RANDOM, DPAD_NEUTRAL, BATT_MAX, PICK);
                queue_frame(FK_GOOD, FILL_RANDOM, DPAD_NEUTRAL + 1, PICK, PICK);
                queue_frame(FK_GOOD, FILL_RANDOM, PICK, BATT_MAX + 1, PICK);
                queue_frame(FK_GOOD, FILL_RANDOM, 0, BATT_UNKNOWN, PICK);
                queue_frame(FK_GOOD, FILL_RANDOM, DPAD_NEUTRAL + 1, BATT_MAX + 1, PICK);
                queue_frame(FK_MAGIC, FILL_RANDOM, PICK, PICK, PICK);
                queue_frame(FK_VERSION, FILL_RANDOM, PICK, PICK, PICK);
                queue_frame(FK_TYPE, FILL_RANDOM, PICK, PICK, PICK);
                queue_frame(FK_CRC, FILL_RANDOM, PICK, PICK, PICK);
                queue_frame(FK_MULTI, FILL_RANDOM, PICK, PICK, PICK);
                queue_frame(FK_SHORT, FILL_RANDOM, PICK, PICK, 1);
                queue_frame(FK_SHORT, FILL_RANDOM, PICK, PICK, FRAME_BYTES - 1);
                queue_frame(FK_LONG, FILL_RANDOM, PICK, PICK, FRAME_BYTES + 1);
                queue_frame(FK_LONG, FILL_RANDOM, PICK, PICK, FRAME_BYTES + 8);
                queue_frame(FK_GOOD, FILL_RANDOM, PICK, PICK, PICK);
            end
            for (int f = 0; f < 3; f++) begin
                queue_frame(pick_kind(), FILL_RANDOM, PICK, PICK, PICK);
            end
            wait_idle();
        end

        repeat (16) @(posedge i_clk);
        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/cfc_pkg.sv
rtl/cfc_in_if.sv
rtl/cfc_out_if.sv
rtl/cfc_frame.sv
rtl/control_frame_checker.sv
verif/control_frame_checker_tb.sv
